// ===== hw/rtl/dos_pkg.sv =====
// Types, constants and the option walk step for the DHCP option search block.
package dos_pkg;

    localparam logic [7:0] HDR_LEN  = 8'd236;
    localparam logic [7:0] PRE_LEN  = 8'd240;
    localparam logic [7:0] OPT_PAD  = 8'd0;
    localparam logic [7:0] OPT_END  = 8'd255;
    localparam logic [7:0] MAGIC_0  = 8'd99;
    localparam logic [7:0] MAGIC_1  = 8'd130;
    localparam logic [7:0] MAGIC_2  = 8'd83;
    localparam logic [7:0] MAGIC_3  = 8'd99;

    localparam int Q_DEPTH  = 8;
    localparam int Q_IDX_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int MAX_RES  = 5;
    localparam int RES_W    = $clog2(MAX_RES + 1);
    localparam logic [Q_CNT_W-1:0] Q_ACCEPT_MAX = Q_CNT_W'(Q_DEPTH - MAX_RES);

    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_SHORT     = 2'd2,
        ST_TRUNC     = 2'd3
    } status_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] bytes_left;
        logic       in_match;
        logic       found;
    } walk_state_t;

    typedef struct packed {
        walk_state_t st;
        logic        emit;
    } walk_res_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        status_t    status;
        logic       is_dhcp;
        logic       last;
    } result_t;

    function automatic walk_res_t walk_step(walk_state_t s, logic [7:0] b,
                                            logic [7:0] wanted);
        walk_res_t  r;
        logic       no_len;
        logic [7:0] left_dec;
        r        = '{st: s, emit: 1'b0};
        no_len   = (b == OPT_PAD) || (b == OPT_END);
        left_dec = s.bytes_left - 8'd1;
        case (s.phase)
            PH_CODE:
            begin
                if (b == wanted)
                begin
                    if (no_len)
                    begin
                        r.st.found    = 1'b1;
                        r.st.in_match = 1'b0;
                        r.st.phase    = PH_DONE;
                    end
                    else
                    begin
                        r.st.in_match = 1'b1;
                        r.st.phase    = PH_LEN;
                    end
                end
                else if (!no_len)
                begin
                    r.st.phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b == 8'd0)
                begin
                    if (s.in_match)
                    begin
                        r.st.found    = 1'b1;
                        r.st.in_match = 1'b0;
                        r.st.phase    = PH_DONE;
                    end
                    else
                    begin
                        r.st.phase = PH_CODE;
                    end
                end
                else
                begin
                    r.st.bytes_left = b;
                    r.st.phase      = PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.emit          = s.in_match;
                r.st.bytes_left = left_dec;
                if (left_dec == 8'd0)
                begin
                    if (s.in_match)
                    begin
                        r.st.found    = 1'b1;
                        r.st.in_match = 1'b0;
                        r.st.phase    = PH_DONE;
                    end
                    else
                    begin
                        r.st.phase = PH_CODE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/dhcp_option_search.sv =====
// Results are registered into the queue when their byte is accepted.
// Throughput: one byte per cycle; results drain one per cycle from an 8-entry queue.
// On a cookie mismatch the cookie-completing byte yields up to five results; input
// is held while more than three results are queued.
// Reset (rst_n low, asynchronous) clears the scan state, the queue and wanted_code.
module dhcp_option_search
    import dos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, [10] is_dhcp, zero fill
    output logic        m_tuser,   // kind
    output logic        m_tlast    // out_last
);

    logic [7:0]        wanted_reg;
    logic [7:0]        hc_reg, hc_next;
    logic [7:0]        ck_reg [0:2];
    walk_state_t       ws_reg, ws_next;
    logic              ok_reg, ok_next;
    result_t           q_reg [0:Q_DEPTH-1];
    result_t           q_next [0:Q_DEPTH-1];
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    logic              acc, pop, pre, ck_done, ck_match;
    logic [7:0]        wb [0:3];
    logic [3:0]        wen;
    walk_res_t         wr [0:3];
    walk_state_t       ws_chain [0:4];
    result_t           items [0:MAX_RES-1];
    logic [MAX_RES-1:0] item_v;
    result_t           list [0:MAX_RES-1];
    logic [RES_W-1:0]  n_new;
    logic [Q_CNT_W-1:0] base;
    status_t           sum_status;
    logic              sum_isd;

    assign acc      = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= Q_ACCEPT_MAX);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {5'd0, q_reg[0].is_dhcp, q_reg[0].status, q_reg[0].data};
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;

    always_comb
    begin
        pre      = (hc_reg < PRE_LEN);
        ck_done  = (hc_reg == PRE_LEN - 8'd1);
        ck_match = (ck_reg[0] == MAGIC_0) && (ck_reg[1] == MAGIC_1) &&
                   (ck_reg[2] == MAGIC_2) && (s_tdata == MAGIC_3);
        hc_next  = pre ? (hc_reg + 8'd1) : hc_reg;
        ok_next  = ok_reg;
        if (pre && ck_done)
        begin
            ok_next = ck_match;
        end

        wb[0] = ck_reg[0];
        wb[1] = ck_reg[1];
        wb[2] = ck_reg[2];
        wb[3] = s_tdata;
        wen   = 4'b0000;
        if (!pre)
        begin
            wb[0] = s_tdata;
            wen   = 4'b0001;
        end
        else if (ck_done && !ck_match)
        begin
            wen = 4'b1111;
        end

        ws_chain[0] = ws_reg;
        for (int k = 0; k < 4; k++)
        begin
            wr[k] = walk_step(ws_chain[k], wb[k], wanted_reg);
            if (wen[k])
            begin
                ws_chain[k+1] = wr[k].st;
            end
            else
            begin
                ws_chain[k+1] = ws_chain[k];
            end
            items[k]  = '{kind: 1'b0, data: wb[k], status: ST_FOUND,
                          is_dhcp: 1'b0, last: 1'b0};
            item_v[k] = wen[k] && wr[k].emit;
        end
        ws_next = ws_chain[4];

        sum_isd = 1'b0;
        if (hc_next < PRE_LEN)
        begin
            sum_status = ST_SHORT;
        end
        else
        begin
            sum_isd = ok_next;
            if (ws_next.found)
            begin
                sum_status = ST_FOUND;
            end
            else if (ws_next.in_match)
            begin
                sum_status = ST_TRUNC;
            end
            else
            begin
                sum_status = ST_NOT_FOUND;
            end
        end
        items[4]  = '{kind: 1'b1, data: 8'd0, status: sum_status,
                      is_dhcp: sum_isd, last: 1'b1};
        item_v[4] = s_tlast;

        if (s_tlast)
        begin
            hc_next = 8'd0;
            ok_next = 1'b0;
            ws_next = '{phase: PH_CODE, bytes_left: 8'd0, in_match: 1'b0, found: 1'b0};
        end

        n_new = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            list[k] = items[4];
        end
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (item_v[k])
            begin
                list[n_new[Q_IDX_W-1:0]] = items[k];
                n_new = n_new + RES_W'(1);
            end
        end

        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        base = cnt_reg;
        if (pop)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            base = cnt_reg - Q_CNT_W'(1);
        end
        cnt_next = base;
        if (acc)
        begin
            for (int j = 0; j < MAX_RES; j++)
            begin
                if (RES_W'(j) < n_new)
                begin
                    q_next[Q_IDX_W'(base + Q_CNT_W'(j))] = list[j];
                end
            end
            cnt_next = base + Q_CNT_W'(n_new);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= 8'd0;
            hc_reg     <= 8'd0;
            ok_reg     <= 1'b0;
            ws_reg     <= '{phase: PH_CODE, bytes_left: 8'd0, in_match: 1'b0, found: 1'b0};
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wanted_reg <= cfg_wr_data;
            end
            if (acc)
            begin
                hc_reg <= hc_next;
                ok_reg <= ok_next;
                ws_reg <= ws_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && pre && (hc_reg >= HDR_LEN) && !ck_done)
        begin
            ck_reg[2'(hc_reg - HDR_LEN)] <= s_tdata;
        end
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule
